FILE: hdl/selective_receive_mailbox_defines.svh
// Assertion macros shared by the mailbox RTL.
`ifndef SELECTIVE_RECEIVE_MAILBOX_DEFINES_SVH
`define SELECTIVE_RECEIVE_MAILBOX_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define SRM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked while out of reset.
`define SRM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/srm_pkg.sv
// Types and codes of the selective-receive mailbox.
`default_nettype none
package srm_pkg;

  localparam int SEL_SLOTS = 4;
  localparam int SEL_CNT_W = 3;
  localparam int CAP_W     = 5;

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_GET   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_CLEARED   = 3'd4
  } srm_status_t;

  typedef struct packed {
    logic [7:0]  client;
    logic [31:0] signal;
    logic [15:0] payload;
  } srm_entry_t;

  // Broadcast search key, same for every cell.
  typedef struct packed {
    logic                       filt;
    logic [7:0]                 cid;
    logic                       any_sig;
    logic [SEL_SLOTS-1:0]       sel_en;
    logic [SEL_SLOTS-1:0][31:0] sel;
  } srm_query_t;

  // Per-cell commit controls.
  typedef struct packed {
    logic wr_en;
    logic shift_en;
  } srm_cell_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/srm_cell.sv
// One mailbox slot: entry storage, match compare and first-hit chain link.
`default_nettype none
module srm_cell (
  input  logic                  clk,
  input  logic                  cap_en,
  input  srm_pkg::srm_query_t   query,
  input  logic                  occupied,
  input  logic                  seen_in,
  output logic                  seen_out,
  output logic                  take,
  input  srm_pkg::srm_cell_ctl_t ctl,
  input  srm_pkg::srm_entry_t   new_entry,
  input  srm_pkg::srm_entry_t   nb_entry,
  output srm_pkg::srm_entry_t   entry
);
  import srm_pkg::*;

  srm_entry_t entry_r, entry_nxt;
  logic       match_r, match_nxt;
  logic       client_ok, sig_ok, hit;

  always_comb begin
    client_ok = !query.filt || (entry_r.client == query.cid);
    sig_ok    = query.any_sig;
    for (int i = 0; i < SEL_SLOTS; i++) begin
      if (query.sel_en[i] && (query.sel[i] == entry_r.signal)) begin
        sig_ok = 1'b1;
      end
    end
    match_nxt = cap_en ? (client_ok & sig_ok) : match_r;
  end

  always_comb begin
    if (ctl.wr_en) begin
      entry_nxt = new_entry;
    end else if (ctl.shift_en) begin
      entry_nxt = nb_entry;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    match_r <= match_nxt;
  end

  // oldest hit wins: pass "already seen" toward the tail
  assign hit      = match_r & occupied;
  assign take     = hit & !seen_in;
  assign seen_out = seen_in | hit;
  assign entry    = entry_r;

endmodule
`default_nettype wire

FILE: hdl/selective_receive_mailbox.sv
// Top level of the selective-receive mailbox: request stage, cell row, result register.
`default_nettype none
`include "selective_receive_mailbox_defines.svh"
// Bounded mailbox kept in arrival order in a row of DEPTH slot cells, oldest at
// cell 0. Add appends at the tail unless occupancy has reached the smaller of
// capacity_limit and DEPTH. Get removes the oldest entry passing the optional
// client filter and the selector list (empty list takes any signal); the cell
// holding it and every cell behind it take their right neighbor's entry to
// close the gap. Clear drops the occupancy to zero. Each item gives one result
// carrying status and occupancy after the item; found_* are zero unless status
// is found. On the transfer edge every cell compares its entry against the
// broadcast key and registers a match bit; at the commit edge, once the output
// register is free, the first hit is picked by a ripple through the cells, the
// row is updated and the result is loaded into the output register. in_stall
// is high from the transfer until that commit, including while a finished item
// waits for the output register to free up. A result waiting at the output
// does not hold off the next input transfer. capacity_limit is written through
// cfg_*, which is always ready; write it only while the block is idle.
module selective_receive_mailbox #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_capacity_limit,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_client_id,
  input  logic [31:0] in_signal_id,
  input  logic [15:0] in_payload_ref,
  input  logic        in_use_client_filter,
  input  logic [2:0]  in_selector_count,
  input  logic [31:0] in_selector_0,
  input  logic [31:0] in_selector_1,
  input  logic [31:0] in_selector_2,
  input  logic [31:0] in_selector_3,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_found_client,
  output logic [31:0] out_found_signal,
  output logic [15:0] out_found_payload,
  output logic [4:0]  out_occupancy
);
  import srm_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // control
  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic             out_valid_r, out_valid_nxt;
  // request payload held for the commit cycle
  logic [1:0]       kind_r;
  srm_entry_t       add_entry_r;
  // result payload
  srm_status_t      status_r, status_nxt;
  srm_entry_t       found_r, found_nxt;
  logic [4:0]       occ_r, occ_nxt;

  logic             in_xfer, commit, add_ok, found;
  logic [CMP_W-1:0] count_ext, cap_ext, count_nxt_ext;
  logic [SEL_CNT_W-1:0] nsel;
  srm_query_t       query;
  srm_entry_t       add_entry_in, found_entry;

  logic       [DEPTH:0]   seen_w;
  logic       [DEPTH-1:0] take_w;
  srm_entry_t             entry_w [DEPTH];
  srm_cell_ctl_t          ctl_w   [DEPTH];

  assign cfg_ready = 1'b1;
  assign in_stall  = busy_r;
  assign in_xfer   = in_valid & !in_stall;
  assign commit    = busy_r & (!out_valid_r | !out_stall);

  // broadcast key straight from the ports; the row is stable while idle
  always_comb begin
    nsel = (in_selector_count > SEL_CNT_W'(SEL_SLOTS)) ? SEL_CNT_W'(SEL_SLOTS)
                                                        : in_selector_count;
    query.filt    = in_use_client_filter;
    query.cid     = in_client_id;
    query.any_sig = (nsel == '0);
    for (int i = 0; i < SEL_SLOTS; i++) begin
      query.sel_en[i] = (SEL_CNT_W'(i) < nsel);
    end
    query.sel[0] = in_selector_0;
    query.sel[1] = in_selector_1;
    query.sel[2] = in_selector_2;
    query.sel[3] = in_selector_3;
  end

  assign add_entry_in.client  = in_client_id;
  assign add_entry_in.signal  = in_signal_id;
  assign add_entry_in.payload = in_payload_ref;

  // effective limit is min(capacity_limit, DEPTH)
  assign count_ext = CMP_W'(count_r);
  assign cap_ext   = CMP_W'(cap_r);
  assign add_ok    = (count_ext < cap_ext) && (count_r < CNT_W'(DEPTH));
  assign found     = seen_w[DEPTH];

  // cell row
  assign seen_w[0] = 1'b0;
  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    srm_entry_t nb;
    if (j == DEPTH - 1) begin : g_last
      assign nb = entry_w[j];
    end else begin : g_mid
      assign nb = entry_w[j+1];
    end

    always_comb begin
      ctl_w[j].wr_en    = commit && (kind_r == KIND_ADD) && add_ok &&
                          (count_r == CNT_W'(j));
      ctl_w[j].shift_en = commit && (kind_r == KIND_GET) && seen_w[j+1];
    end

    srm_cell u_cell (
      .clk       (clk),
      .cap_en    (in_xfer),
      .query     (query),
      .occupied  (CNT_W'(j) < count_r),
      .seen_in   (seen_w[j]),
      .seen_out  (seen_w[j+1]),
      .take      (take_w[j]),
      .ctl       (ctl_w[j]),
      .new_entry (add_entry_r),
      .nb_entry  (nb),
      .entry     (entry_w[j])
    );
  end

  // one-hot read of the removed entry
  always_comb begin
    found_entry = '0;
    for (int j = 0; j < DEPTH; j++) begin
      if (take_w[j]) begin
        found_entry = found_entry | entry_w[j];
      end
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    count_nxt     = count_r;
    cap_nxt       = cap_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    occ_nxt       = occ_r;

    if (cfg_valid && cfg_ready) begin
      cap_nxt = cfg_capacity_limit;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (in_xfer) begin
      busy_nxt = 1'b1;
    end

    if (commit) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      found_nxt     = '0;
      status_nxt    = ST_NOT_FOUND;
      case (kind_r)
        KIND_ADD: begin
          if (add_ok) begin
            count_nxt  = count_r + 1'b1;
            status_nxt = ST_ADDED;
          end else begin
            status_nxt = ST_FULL;
          end
        end
        KIND_GET: begin
          if (found) begin
            count_nxt  = count_r - 1'b1;
            status_nxt = ST_FOUND;
            found_nxt  = found_entry;
          end
        end
        KIND_CLEAR: begin
          count_nxt  = '0;
          status_nxt = ST_CLEARED;
        end
        default: begin
          status_nxt = ST_NOT_FOUND;
        end
      endcase
    end

    count_nxt_ext = CMP_W'(count_nxt);
    if (commit) begin
      occ_nxt = count_nxt_ext[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      cap_r       <= CAP_W'(16);
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_xfer) begin
      kind_r      <= in_kind;
      add_entry_r <= add_entry_in;
    end
    status_r <= status_nxt;
    found_r  <= found_nxt;
    occ_r    <= occ_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_found_client  = found_r.client;
  assign out_found_signal  = found_r.signal;
  assign out_found_payload = found_r.payload;
  assign out_occupancy     = occ_r;

  `SRM_ASSERT_IMP(a_take_onehot, clk, rst_n, busy_r, $onehot0(take_w), "more than one slot taken")
  `SRM_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH), "occupancy above depth")
  `SRM_ASSERT_NXT(a_commit_out, clk, rst_n, commit, out_valid_r && !busy_r, "commit lost its result")
  `SRM_ASSERT_NXT(a_add_count, clk, rst_n, commit && (kind_r == KIND_ADD) && add_ok, count_r == $past(count_r) + 1'b1, "add did not grow occupancy")

endmodule
`default_nettype wire

FILE: verif/selective_receive_mailbox_test.sv
// Testbench of the selective-receive mailbox: directed cases, random phases, backpressure.
`timescale 1ns / 100ps

module selective_receive_mailbox_test;
  import srm_pkg::*;

  localparam int MB_DEPTH     = 16;
  localparam int HOLD_CYCLES  = 400;      // long receiver hold-off in the backpressure test
  localparam int CYCLE_LIMIT  = 200000;   // watchdog limit on the whole run
  localparam int PHASE_ITEMS  = 200;

  // Kind 3 is not decoded by the block; it must come back as not found.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // One request as presented on the in_* ports.
  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       client;
    logic [31:0]      signal;
    logic [15:0]      payload;
    logic             filt;
    logic [2:0]       sel_cnt;
    logic [3:0][31:0] sel;
  } mb_request_t;

  // One result as seen on the out_* ports.
  typedef struct packed {
    srm_status_t status;
    logic [7:0]  client;
    logic [31:0] signal;
    logic [15:0] payload;
    logic [4:0]  occupancy;
  } mb_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_capacity_limit = '0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = '0;
  logic [7:0]  in_client_id = '0;
  logic [31:0] in_signal_id = '0;
  logic [15:0] in_payload_ref = '0;
  logic        in_use_client_filter = 1'b0;
  logic [2:0]  in_selector_count = '0;
  logic [31:0] in_selector_0 = '0;
  logic [31:0] in_selector_1 = '0;
  logic [31:0] in_selector_2 = '0;
  logic [31:0] in_selector_3 = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [7:0]  out_found_client;
  logic [31:0] out_found_signal;
  logic [15:0] out_found_payload;
  logic [4:0]  out_occupancy;

  selective_receive_mailbox #(.DEPTH(MB_DEPTH)) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_capacity_limit   (cfg_capacity_limit),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_kind              (in_kind),
    .in_client_id         (in_client_id),
    .in_signal_id         (in_signal_id),
    .in_payload_ref       (in_payload_ref),
    .in_use_client_filter (in_use_client_filter),
    .in_selector_count    (in_selector_count),
    .in_selector_0        (in_selector_0),
    .in_selector_1        (in_selector_1),
    .in_selector_2        (in_selector_2),
    .in_selector_3        (in_selector_3),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_found_client     (out_found_client),
    .out_found_signal     (out_found_signal),
    .out_found_payload    (out_found_payload),
    .out_occupancy        (out_occupancy)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Mailbox predictor: arrival-ordered entries, oldest at index 0, and the
  // capacity register as last written.
  // ---------------------------------------------------------------------------
  srm_entry_t  held_entries[$];
  logic [4:0]  capacity_shadow = 5'd16;
  mb_reply_t   pending_results[$];
  int          mismatch_count = 0;

  function automatic bit entry_selected(srm_entry_t e, mb_request_t r, int nsel);
    if (r.filt && e.client != r.client) return 1'b0;
    if (nsel == 0) return 1'b1;
    for (int i = 0; i < nsel; i++) begin
      if (r.sel[i] == e.signal) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Applies one accepted request to the shadow mailbox, returns its result.
  function automatic mb_reply_t mailbox_apply(mb_request_t r);
    mb_reply_t  res;
    srm_entry_t ent;
    int         lim;
    int         nsel;
    int         hit;
    res.status  = ST_NOT_FOUND;
    res.client  = '0;
    res.signal  = '0;
    res.payload = '0;
    case (r.kind)
      KIND_ADD: begin
        // a limit above the depth saturates at the depth
        lim = (int'(capacity_shadow) > MB_DEPTH) ? MB_DEPTH : int'(capacity_shadow);
        if (held_entries.size() < lim) begin
          ent.client  = r.client;
          ent.signal  = r.signal;
          ent.payload = r.payload;
          held_entries.insert(held_entries.size(), ent);
          res.status = ST_ADDED;
        end else begin
          res.status = ST_FULL;
        end
      end
      KIND_GET: begin
        nsel = (int'(r.sel_cnt) > SEL_SLOTS) ? SEL_SLOTS : int'(r.sel_cnt);
        hit = -1;
        foreach (held_entries[k]) begin
          if (hit < 0 && entry_selected(held_entries[k], r, nsel)) hit = k;
        end
        if (hit >= 0) begin
          res.status  = ST_FOUND;
          res.client  = held_entries[hit].client;
          res.signal  = held_entries[hit].signal;
          res.payload = held_entries[hit].payload;
          held_entries.delete(hit);
        end
      end
      KIND_CLEAR: begin
        held_entries.delete();
        res.status = ST_CLEARED;
      end
      default: ;
    endcase
    res.occupancy = 5'(held_entries.size());
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every out_* transfer is matched against the oldest
  // pending result, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    mb_reply_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing pending: status %0d occupancy %0d",
               out_status, out_occupancy);
        mismatch_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, out_status);
          mismatch_count++;
        end
        if (out_found_client !== exp_res.client) begin
          $error("found_client: expected %0h, got %0h", exp_res.client, out_found_client);
          mismatch_count++;
        end
        if (out_found_signal !== exp_res.signal) begin
          $error("found_signal: expected %0h, got %0h", exp_res.signal, out_found_signal);
          mismatch_count++;
        end
        if (out_found_payload !== exp_res.payload) begin
          $error("found_payload: expected %0h, got %0h", exp_res.payload, out_found_payload);
          mismatch_count++;
        end
        if (out_occupancy !== exp_res.occupancy) begin
          $error("occupancy: expected %0d, got %0d", exp_res.occupancy, out_occupancy);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stalls on a pattern that is redrawn whenever its run expires (none,
  // light random, heavy random, periodic). A bump of hold_request forces a
  // long hold-off, counted here.
  // ---------------------------------------------------------------------------
  int hold_request = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int stall_mode   = 0;
  int mode_left    = 0;
  int pattern_ctr  = 0;

  always @(posedge clk) begin
    pattern_ctr <= pattern_ctr + 1;
    if (hold_seen != hold_request) begin
      hold_seen <= hold_request;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode_left  <= $urandom_range(16, 96);
        stall_mode <= $urandom_range(0, 3);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (pattern_ctr % 7) < 3;
      endcase
    end
  end

  // Watchdog.
  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side. All tasks are entered right after a rising edge.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_max    = 6;   // 0 gives back-to-back transfers

  // Drives one request and holds it until the transfer edge, then predicts.
  task automatic post_request(input mb_request_t r);
    in_valid             <= 1'b1;
    in_kind              <= r.kind;
    in_client_id         <= r.client;
    in_signal_id         <= r.signal;
    in_payload_ref       <= r.payload;
    in_use_client_filter <= r.filt;
    in_selector_count    <= r.sel_cnt;
    in_selector_0        <= r.sel[0];
    in_selector_1        <= r.sel[1];
    in_selector_2        <= r.sel[2];
    in_selector_3        <= r.sel[3];
    do @(posedge clk); while (in_stall);
    pending_results.insert(pending_results.size(), mailbox_apply(r));
  endtask

  // Bursts of random length with random gaps in between.
  task automatic sender_pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic paced_request(input mb_request_t r);
    sender_pace();
    post_request(r);
  endtask

  // Waits until every result has come back and the pipeline is empty.
  task automatic drain_mailbox();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Capacity write; only called while drained.
  task automatic write_capacity(input logic [4:0] value);
    cfg_valid          <= 1'b1;
    cfg_capacity_limit <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    capacity_shadow = value;
  endtask

  function automatic mb_request_t build_request(logic [1:0] kind, logic [7:0] client,
                                                logic [31:0] signal, logic [15:0] payload,
                                                logic filt, logic [2:0] cnt,
                                                logic [31:0] s0, logic [31:0] s1,
                                                logic [31:0] s2, logic [31:0] s3);
    mb_request_t r;
    r.kind    = kind;
    r.client  = client;
    r.signal  = signal;
    r.payload = payload;
    r.filt    = filt;
    r.sel_cnt = cnt;
    r.sel     = {s3, s2, s1, s0};
    return r;
  endfunction

  // Small pools make matches likely; full-range values keep every bit moving.
  function automatic logic [7:0] pick_client();
    return ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
  endfunction

  function automatic logic [31:0] pick_signal();
    return ($urandom_range(0, 3) != 0) ? 32'($urandom_range(0, 7)) : 32'($urandom);
  endfunction

  // Mostly adds and gets aimed at held entries; a little clear and kind 3.
  function automatic mb_request_t random_request();
    mb_request_t r;
    srm_entry_t  tgt;
    int          pick;
    int          slot;
    int          nsel;
    r.client  = pick_client();
    r.signal  = pick_signal();
    r.payload = 16'($urandom);
    r.filt    = 1'($urandom);
    r.sel_cnt = 3'($urandom_range(0, 7));
    for (int i = 0; i < SEL_SLOTS; i++) r.sel[i] = pick_signal();
    pick = $urandom_range(0, 99);
    if (pick < 50)      r.kind = KIND_ADD;
    else if (pick < 96) r.kind = KIND_GET;
    else if (pick < 98) r.kind = KIND_CLEAR;
    else                r.kind = KIND_UNUSED;
    if (r.kind == KIND_GET && held_entries.size() != 0 && $urandom_range(0, 99) < 70) begin
      tgt = held_entries[$urandom_range(0, held_entries.size() - 1)];
      if (r.filt) r.client = tgt.client;
      if ($urandom_range(0, 3) == 0) begin
        r.sel_cnt = '0;
      end else begin
        r.sel_cnt = 3'($urandom_range(1, ($urandom_range(0, 4) == 0) ? 7 : 4));
        nsel = (int'(r.sel_cnt) > SEL_SLOTS) ? SEL_SLOTS : int'(r.sel_cnt);
        slot = $urandom_range(0, nsel - 1);
        r.sel[slot] = tgt.signal;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every kind, filter, selector saturation, duplicates,
  // empty get, zero capacity and a limit dropped below occupancy.
  task automatic test_directed_cases();
    gap_max = 3;
    paced_request(build_request(KIND_GET, 8'h00, '0, '0, 1'b0, 3'd0, '0, '0, '0, '0));
    paced_request(build_request(KIND_UNUSED, 8'hff, '1, '1, 1'b1, 3'd7, '1, '1, '1, '1));
    paced_request(build_request(KIND_ADD, 8'h00, 32'h0, 16'h0, 1'b0, 3'd0, '0, '0, '0, '0));
    paced_request(build_request(KIND_ADD, 8'hff, 32'hffff_ffff, 16'hffff, 1'b1, 3'd7,
                                '1, '1, '1, '1));
    paced_request(build_request(KIND_ADD, 8'h12, 32'ha5a5_0f0f, 16'h1234, 1'b0, 3'd0,
                                '0, '0, '0, '0));
    // filter alone picks the middle entry
    paced_request(build_request(KIND_GET, 8'hff, '0, '0, 1'b1, 3'd0, '0, '0, '0, '0));
    // filter on an absent client
    paced_request(build_request(KIND_GET, 8'h34, '0, '0, 1'b1, 3'd0, '0, '0, '0, '0));
    // duplicated selectors
    paced_request(build_request(KIND_GET, 8'h00, '0, '0, 1'b0, 3'd2,
                                32'ha5a5_0f0f, 32'ha5a5_0f0f, '0, '0));
    // count of 7 saturates to four: only the last slot matches
    paced_request(build_request(KIND_GET, 8'h00, '0, '0, 1'b0, 3'd7,
                                32'h1, 32'h2, 32'h3, 32'h0));
    paced_request(build_request(KIND_GET, 8'h00, '0, '0, 1'b0, 3'd0, '0, '0, '0, '0));
    paced_request(build_request(KIND_ADD, 8'h01, 32'h10, 16'h10, 1'b0, 3'd0, '0, '0, '0, '0));
    paced_request(build_request(KIND_CLEAR, 8'h00, '0, '0, 1'b0, 3'd0, '0, '0, '0, '0));
    paced_request(build_request(KIND_GET, 8'h00, '0, '0, 1'b0, 3'd0, '0, '0, '0, '0));
    drain_mailbox();
    // zero capacity rejects everything
    write_capacity(5'd0);
    paced_request(build_request(KIND_ADD, 8'h05, 32'h5, 16'h5, 1'b0, 3'd0, '0, '0, '0, '0));
    drain_mailbox();
    write_capacity(5'd3);
    paced_request(build_request(KIND_ADD, 8'h21, 32'h100, 16'h1, 1'b0, 3'd0, '0, '0, '0, '0));
    paced_request(build_request(KIND_ADD, 8'h22, 32'h200, 16'h2, 1'b0, 3'd0, '0, '0, '0, '0));
    paced_request(build_request(KIND_ADD, 8'h23, 32'h300, 16'h3, 1'b0, 3'd0, '0, '0, '0, '0));
    drain_mailbox();
    // limit now below occupancy: held entries stay, adds bounce
    write_capacity(5'd1);
    paced_request(build_request(KIND_ADD, 8'h24, 32'h400, 16'h4, 1'b0, 3'd0, '0, '0, '0, '0));
    paced_request(build_request(KIND_GET, 8'h00, '0, '0, 1'b0, 3'd4,
                                32'h7, 32'h8, 32'h9, 32'ha));
    // removing from the middle closes the gap
    paced_request(build_request(KIND_GET, 8'h00, '0, '0, 1'b0, 3'd1, 32'h200, '0, '0, '0));
    paced_request(build_request(KIND_GET, 8'h00, '0, '0, 1'b0, 3'd0, '0, '0, '0, '0));
    paced_request(build_request(KIND_ADD, 8'h25, 32'h500, 16'h5, 1'b0, 3'd0, '0, '0, '0, '0));
    paced_request(build_request(KIND_GET, 8'h00, '0, '0, 1'b0, 3'd0, '0, '0, '0, '0));
    paced_request(build_request(KIND_ADD, 8'h26, 32'h600, 16'h6, 1'b0, 3'd0, '0, '0, '0, '0));
    paced_request(build_request(KIND_CLEAR, 8'h00, '0, '0, 1'b0, 3'd0, '0, '0, '0, '0));
    drain_mailbox();
  endtask

  // One random phase at a given capacity; entries carry over between phases.
  task automatic run_random_phase(input logic [4:0] cap);
    write_capacity(cap);
    gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    for (int n = 0; n < PHASE_ITEMS; n++) paced_request(random_request());
    drain_mailbox();
  endtask

  task automatic test_capacity_sweep();
    run_random_phase(5'd16);
    run_random_phase(5'd31);   // above the depth
    run_random_phase(5'd5);
    run_random_phase(5'd0);
    run_random_phase(5'd1);
    run_random_phase(5'd17);
    run_random_phase(5'($urandom_range(0, 31)));
    run_random_phase(5'd2);
    run_random_phase(5'd16);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // back to back, so the output fills and in_stall must hold the input.
  task automatic test_backpressure();
    write_capacity(5'd16);
    hold_request <= hold_request + 1;
    gap_max = 0;
    for (int n = 0; n < 40; n++) post_request(random_request());
    drain_mailbox();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_capacity_sweep();
    test_backpressure();
    drain_mailbox();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
